// ===== hdl/mot_pkg.sv =====
`timescale 1ns / 1ps

package mot_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int OP_W         = 3;
  localparam int CH_W         = 3;
  localparam int TIME_W       = 32;
  localparam int KIND_W       = 2;
  localparam int CMP_W        = 6;
  localparam int FIRE_LIMIT   = 8;

  localparam logic [TIME_W-1:0] STOPPED = '1;
  localparam logic [TIME_W-1:0] DUE_MAX = {{(TIME_W-1){1'b1}}, 1'b0};

  typedef enum logic [OP_W-1:0] {
    OP_TICK           = 3'd0,
    OP_SET_PERIOD     = 3'd1,
    OP_START_ONCE     = 3'd2,
    OP_START_PERIODIC = 3'd3,
    OP_DISABLE        = 3'd4,
    OP_QUERY          = 3'd5
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDLE_TICK = 2'd0,
    KIND_FIRED     = 2'd1,
    KIND_ACK       = 2'd2,
    KIND_QUERY     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load_fire;
    logic load_resp;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic fire_zero;
    logic fired_here;
    logic last_fire;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/mot_if.sv =====
`timescale 1ns / 1ps

interface mot_in_if;
  logic                        valid;
  logic                        ready;
  logic [mot_pkg::OP_W-1:0]    operation;
  logic [mot_pkg::CH_W-1:0]    channel;
  logic [mot_pkg::TIME_W-1:0]  period_ms;

  modport source (output valid, output operation, output channel, output period_ms,
                  input ready);
  modport sink (input valid, input operation, input channel, input period_ms,
                output ready);
endinterface

interface mot_out_if;
  logic                        valid;
  logic                        ready;
  logic [mot_pkg::KIND_W-1:0]  kind;
  logic [mot_pkg::CH_W-1:0]    fired_channel;
  logic                        running;
  logic [mot_pkg::TIME_W-1:0]  nearest_due;
  logic                        last;

  modport source (output valid, output kind, output fired_channel, output running,
                  output nearest_due, output last, input ready);
  modport sink (input valid, input kind, input fired_channel, input running,
                input nearest_due, input last, output ready);
endinterface

// ===== hdl/mot_ctrl.sv =====
`timescale 1ns / 1ps

module mot_ctrl #(
  parameter int  CHANNELS = mot_pkg::CHANNELS_DEF,
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mot_pkg::status_t st,
  output mot_pkg::cmd_t    cmd,
  output logic [IDX_W-1:0] idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  mot_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mot_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      mot_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          idx_nxt    = '0;
          state_nxt  = mot_pkg::ST_SCAN;
        end
      end
      mot_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = st.is_tick ? mot_pkg::ST_EMIT : mot_pkg::ST_RESP;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      mot_pkg::ST_EMIT: begin
        if (st.fire_zero) begin
          state_nxt = mot_pkg::ST_RESP;
        end else if (st.fired_here) begin
          if (st.out_free) begin
            cmd.load_fire = 1'b1;
            if (st.last_fire) begin
              state_nxt = mot_pkg::ST_IDLE;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      mot_pkg::ST_RESP: begin
        if (st.out_free) begin
          cmd.load_resp = 1'b1;
          state_nxt     = mot_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mot_pkg::ST_IDLE;
      end
    endcase
  end

  assign idx = idx_r;

endmodule

// ===== hdl/mot_dp.sv =====
`timescale 1ns / 1ps

module mot_dp #(
  parameter int  CHANNELS = mot_pkg::CHANNELS_DEF,
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int CNT_W    = $clog2(CHANNELS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mot_pkg::cmd_t               cmd,
  input  logic [IDX_W-1:0]            idx,
  output mot_pkg::status_t            st,
  input  logic [mot_pkg::OP_W-1:0]    in_operation,
  input  logic [mot_pkg::CH_W-1:0]    in_channel,
  input  logic [mot_pkg::TIME_W-1:0]  in_period_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mot_pkg::KIND_W-1:0]  out_kind,
  output logic [mot_pkg::CH_W-1:0]    out_fired_channel,
  output logic                        out_running,
  output logic [mot_pkg::TIME_W-1:0]  out_nearest_due,
  output logic                        out_last
);

  localparam int TW = mot_pkg::TIME_W;
  localparam int CW = mot_pkg::CMP_W;

  logic [TW-1:0]                now_r;
  logic [TW-1:0]                due_r [CHANNELS];
  logic [TW-1:0]                per_r [CHANNELS];
  logic [CHANNELS-1:0]          rep_r;
  logic [CHANNELS-1:0]          fired_r;
  logic [CHANNELS-1:0]          runmask_r;
  logic [CNT_W-1:0]             fire_cnt_r;
  logic [CNT_W-1:0]             emit_cnt_r;
  logic [TW-1:0]                near_r;
  logic                         run_resp_r;
  logic                         out_valid_r;

  logic [mot_pkg::OP_W-1:0]     op_r;
  logic [mot_pkg::CH_W-1:0]     ch_r;
  logic [TW-1:0]                pin_r;
  logic [mot_pkg::KIND_W-1:0]   kind_r;
  logic [mot_pkg::CH_W-1:0]     fch_r;
  logic                         run_r;
  logic [TW-1:0]                ndue_r;
  logic                         last_r;

  logic [TW-1:0]                cur_d, cur_p, eff_p, base, clamped;
  logic [TW:0]                  sum;
  logic [CW-1:0]                idx_ext, ch_ext;
  logic                         is_tick, fire, hit;
  logic [TW-1:0]                new_d, new_p;
  logic                         new_rep;
  logic                         last_fire;

  assign is_tick = (op_r == mot_pkg::OP_TICK);
  assign cur_d   = due_r[idx];
  assign cur_p   = per_r[idx];
  assign eff_p   = (cur_p == '0) ? TW'(1) : cur_p;
  assign base    = is_tick ? cur_d : now_r;
  assign sum     = {1'b0, base} + {1'b0, eff_p};
  assign clamped = (sum > {1'b0, mot_pkg::DUE_MAX}) ? mot_pkg::DUE_MAX : sum[TW-1:0];
  assign idx_ext = CW'(idx);
  assign ch_ext  = CW'(ch_r);
  assign fire    = is_tick && (idx_ext < CW'(mot_pkg::FIRE_LIMIT)) &&
                   (cur_d != mot_pkg::STOPPED) && (cur_d <= now_r);
  assign hit     = !is_tick && (idx_ext == ch_ext);

  always_comb begin
    new_d   = cur_d;
    new_p   = cur_p;
    new_rep = rep_r[idx];
    if (fire) begin
      new_d = rep_r[idx] ? clamped : mot_pkg::STOPPED;
    end
    if (hit) begin
      unique case (op_r)
        mot_pkg::OP_SET_PERIOD: begin
          new_p = pin_r;
        end
        mot_pkg::OP_START_ONCE, mot_pkg::OP_START_PERIODIC: begin
          new_rep = (op_r == mot_pkg::OP_START_PERIODIC);
          new_d   = clamped;
        end
        mot_pkg::OP_DISABLE: begin
          new_d   = mot_pkg::STOPPED;
          new_rep = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign last_fire = ((emit_cnt_r + CNT_W'(1)) == fire_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      rep_r       <= '0;
      fired_r     <= '0;
      runmask_r   <= '0;
      fire_cnt_r  <= '0;
      emit_cnt_r  <= '0;
      near_r      <= mot_pkg::STOPPED;
      run_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        due_r[i] <= mot_pkg::STOPPED;
        per_r[i] <= '0;
      end
    end else begin
      if (cmd.accept) begin
        if (in_operation == mot_pkg::OP_TICK) begin
          now_r <= now_r + TW'(1);
        end
        fired_r    <= '0;
        runmask_r  <= '0;
        fire_cnt_r <= '0;
        emit_cnt_r <= '0;
        near_r     <= mot_pkg::STOPPED;
        run_resp_r <= 1'b0;
      end
      if (cmd.scan) begin
        due_r[idx] <= new_d;
        per_r[idx] <= new_p;
        rep_r[idx] <= new_rep;
        if (new_d < near_r) begin
          near_r <= new_d;
        end
        if (fire) begin
          fired_r[idx]   <= 1'b1;
          runmask_r[idx] <= (new_d != mot_pkg::STOPPED);
          fire_cnt_r     <= fire_cnt_r + CNT_W'(1);
        end
        if (hit) begin
          run_resp_r <= (new_d != mot_pkg::STOPPED);
        end
      end
      if (cmd.load_fire) begin
        out_valid_r <= 1'b1;
        emit_cnt_r  <= emit_cnt_r + CNT_W'(1);
      end else if (cmd.load_resp) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      ch_r  <= in_channel;
      pin_r <= in_period_ms;
    end
    if (cmd.load_fire) begin
      kind_r <= mot_pkg::KIND_FIRED;
      fch_r  <= idx_ext[mot_pkg::CH_W-1:0];
      run_r  <= runmask_r[idx];
      ndue_r <= near_r;
      last_r <= last_fire;
    end else if (cmd.load_resp) begin
      if (is_tick) begin
        kind_r <= mot_pkg::KIND_IDLE_TICK;
      end else if (op_r == mot_pkg::OP_QUERY) begin
        kind_r <= mot_pkg::KIND_QUERY;
      end else begin
        kind_r <= mot_pkg::KIND_ACK;
      end
      fch_r  <= is_tick ? '0 : ch_r;
      run_r  <= is_tick ? 1'b0 : run_resp_r;
      ndue_r <= near_r;
      last_r <= 1'b1;
    end
  end

  assign st.is_tick    = is_tick;
  assign st.fire_zero  = (fire_cnt_r == '0);
  assign st.fired_here = fired_r[idx];
  assign st.last_fire  = last_fire;
  assign st.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_fired_channel = fch_r;
  assign out_running       = run_r;
  assign out_nearest_due   = ndue_r;
  assign out_last          = last_r;

endmodule

// ===== hdl/multichannel_oneshot_periodic_timer.sv =====
`timescale 1ns / 1ps
// An item is taken only in the idle state; the channels are then scanned in turn, and a command
// or a quiet tick gives one result. A tick that fires walks the fired mask, one channel a cycle
// except while a fired channel's result waits on out_ch, with one result per fired channel.
// A new item is taken only after the last result of the one before is loaded into the output
// register; out_ch stalls hold that back.
// Reset (synchronous, rst_n low): counter zero, all channels stopped, periods zero.

module multichannel_oneshot_periodic_timer #(
  parameter int CHANNELS = mot_pkg::CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mot_in_if.sink    in_ch,
  mot_out_if.source out_ch
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  mot_pkg::cmd_t    cmd;
  mot_pkg::status_t st;
  logic [IDX_W-1:0] idx;

  mot_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd),
    .idx      (idx)
  );

  mot_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .idx               (idx),
    .st                (st),
    .in_operation      (in_ch.operation),
    .in_channel        (in_ch.channel),
    .in_period_ms      (in_ch.period_ms),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_kind          (out_ch.kind),
    .out_fired_channel (out_ch.fired_channel),
    .out_running       (out_ch.running),
    .out_nearest_due   (out_ch.nearest_due),
    .out_last          (out_ch.last)
  );

endmodule

// ===== hdl/mot_checker.sv =====
`timescale 1ns / 1ps

module mot_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mot_pkg::KIND_W-1:0]  out_kind,
  input logic [mot_pkg::CH_W-1:0]    out_fired_channel,
  input logic                        out_running,
  input logic [mot_pkg::TIME_W-1:0]  out_nearest_due,
  input logic                        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken during channel scan");

  a_quiet_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == mot_pkg::KIND_IDLE_TICK) |->
      out_last && (out_fired_channel == '0) && !out_running)
    else $error("quiet tick result malformed");

  a_running_has_due: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_running |-> (out_nearest_due != mot_pkg::STOPPED))
    else $error("running channel but no nearest due time");

  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("new item taken before all results were formed");

endmodule

bind multichannel_oneshot_periodic_timer mot_checker u_mot_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_fired_channel (out_ch.fired_channel),
  .out_running       (out_ch.running),
  .out_nearest_due   (out_ch.nearest_due),
  .out_last          (out_ch.last)
);

// ===== sim/multichannel_oneshot_periodic_timer_tb.sv =====
`timescale 1ns / 1ps

module multichannel_oneshot_periodic_timer_tb;

  localparam int NCH = mot_pkg::CHANNELS_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_PER_PHASE = 112;

  typedef struct {
    mot_pkg::op_t                   op;
    logic [mot_pkg::CH_W-1:0]       ch;
    logic [mot_pkg::TIME_W-1:0]     per;
  } timer_cmd_t;

  typedef struct {
    mot_pkg::kind_t                 kind;
    logic [mot_pkg::CH_W-1:0]       ch;
    logic                           running;
    logic [mot_pkg::TIME_W-1:0]     nearest;
    logic                           last;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mot_in_if  in_if();
  mot_out_if out_if();

  multichannel_oneshot_periodic_timer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #2 clk = ~clk;

  timer_cmd_t    pending_cmds[$];
  timer_result_t expected_results[$];

  logic [mot_pkg::TIME_W-1:0] now_ms_q;
  logic [mot_pkg::TIME_W-1:0] due_q[NCH];
  logic [mot_pkg::TIME_W-1:0] per_q[NCH];
  logic                       rep_q[NCH];

  int   send_idle_pct = 0;
  int   out_stall_pct = 0;
  int   errors = 0;
  int   quiet_cycles = 0;
  logic in_taken = 1'b0;

  function automatic logic [mot_pkg::TIME_W-1:0] nearest_due_time();
    logic [mot_pkg::TIME_W-1:0] best;
    best = mot_pkg::STOPPED;
    for (int i = 0; i < NCH; i++)
      if (due_q[i] < best) best = due_q[i];
    return best;
  endfunction

  function automatic logic [mot_pkg::TIME_W-1:0] clamp_due(logic [63:0] t);
    return (t > {32'd0, mot_pkg::DUE_MAX}) ? mot_pkg::DUE_MAX : t[mot_pkg::TIME_W-1:0];
  endfunction

  function automatic void predict_command(mot_pkg::op_t op, logic [mot_pkg::CH_W-1:0] ch,
                                          logic [mot_pkg::TIME_W-1:0] per);
    timer_result_t              r;
    logic [mot_pkg::CH_W-1:0]   fired[$];
    logic [63:0]                p, gap, steps;
    logic [mot_pkg::TIME_W-1:0] d, near;
    int                         k;
    if (op == mot_pkg::OP_TICK) begin
      now_ms_q = now_ms_q + 1;
      for (int i = 0; i < NCH; i++) begin
        d = due_q[i];
        if (d != mot_pkg::STOPPED && d <= now_ms_q) begin
          fired.push_back(mot_pkg::CH_W'(i));
          if (rep_q[i]) begin
            p = (per_q[i] == 0) ? 64'd1 : {32'd0, per_q[i]};
            gap = {32'd0, now_ms_q - d};
            steps = (gap + p - 1) / p;
            if (steps == 0) steps = 1;
            due_q[i] = clamp_due({32'd0, d} + steps * p);
          end else begin
            due_q[i] = mot_pkg::STOPPED;
          end
        end
      end
      near = nearest_due_time();
      if (fired.size() == 0) begin
        r.kind = mot_pkg::KIND_IDLE_TICK;
        r.ch = '0;
        r.running = 1'b0;
        r.nearest = near;
        r.last = 1'b1;
        expected_results.push_back(r);
      end else begin
        for (k = 0; k < fired.size(); k++) begin
          r.kind = mot_pkg::KIND_FIRED;
          r.ch = fired[k];
          r.running = (due_q[fired[k]] != mot_pkg::STOPPED);
          r.nearest = near;
          r.last = (k == fired.size() - 1);
          expected_results.push_back(r);
        end
      end
    end else begin
      case (op)
        mot_pkg::OP_SET_PERIOD: per_q[ch] = per;
        mot_pkg::OP_START_ONCE, mot_pkg::OP_START_PERIODIC: begin
          rep_q[ch] = (op == mot_pkg::OP_START_PERIODIC);
          p = (per_q[ch] == 0) ? 64'd1 : {32'd0, per_q[ch]};
          due_q[ch] = clamp_due({32'd0, now_ms_q} + p);
        end
        mot_pkg::OP_DISABLE: begin
          due_q[ch] = mot_pkg::STOPPED;
          rep_q[ch] = 1'b0;
        end
        default: ;
      endcase
      r.kind = (op == mot_pkg::OP_QUERY) ? mot_pkg::KIND_QUERY : mot_pkg::KIND_ACK;
      r.ch = ch;
      r.running = (due_q[ch] != mot_pkg::STOPPED);
      r.nearest = nearest_due_time();
      r.last = 1'b1;
      expected_results.push_back(r);
    end
  endfunction

  function automatic void queue_cmd(mot_pkg::op_t op, logic [mot_pkg::CH_W-1:0] ch,
                                    logic [mot_pkg::TIME_W-1:0] per);
    timer_cmd_t c;
    c.op = op;
    c.ch = ch;
    c.per = per;
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [mot_pkg::TIME_W-1:0] random_period();
    logic [mot_pkg::TIME_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: v = $urandom_range(0, 6);
      6, 7:             v = $urandom_range(7, 40);
      8:                v = $urandom;
      default: begin
        case ($urandom_range(2))
          0:       v = '0;
          1:       v = mot_pkg::DUE_MAX;
          default: v = 32'h8000_0000;
        endcase
      end
    endcase
    if (v == mot_pkg::STOPPED) v = mot_pkg::DUE_MAX;
    return v;
  endfunction

  function automatic void queue_random_cmd();
    int           pick;
    mot_pkg::op_t op;
    pick = $urandom_range(99);
    if (pick < 44)      op = mot_pkg::OP_TICK;
    else if (pick < 56) op = mot_pkg::OP_SET_PERIOD;
    else if (pick < 67) op = mot_pkg::OP_START_ONCE;
    else if (pick < 78) op = mot_pkg::OP_START_PERIODIC;
    else if (pick < 86) op = mot_pkg::OP_DISABLE;
    else                op = mot_pkg::OP_QUERY;
    queue_cmd(op, mot_pkg::CH_W'($urandom_range(NCH - 1)), random_period());
  endfunction

  // sender: advance to the next item once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.operation <= pending_cmds[0].op;
        in_if.channel   <= pending_cmds[0].ch;
        in_if.period_ms <= pending_cmds[0].per;
        void'(pending_cmds.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready)
        predict_command(mot_pkg::op_t'(in_if.operation), in_if.channel, in_if.period_ms);
    end
  end

  always @(posedge clk) begin
    timer_result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d ch %0d running %0d nearest %h last %0d",
                 $time, out_if.kind, out_if.fired_channel, out_if.running,
                 out_if.nearest_due, out_if.last);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_if.kind !== e.kind || out_if.fired_channel !== e.ch ||
            out_if.running !== e.running || out_if.nearest_due !== e.nearest ||
            out_if.last !== e.last) begin
          $display("%0t: expected kind %0d ch %0d running %0d nearest %h last %0d",
                   $time, e.kind, e.ch, e.running, e.nearest, e.last);
          $display("%0t: actual   kind %0d ch %0d running %0d nearest %h last %0d",
                   $time, out_if.kind, out_if.fired_channel, out_if.running,
                   out_if.nearest_due, out_if.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("multichannel_oneshot_periodic_timer: mismatch");
      $finish;
    end
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.operation = '0;
    in_if.channel   = '0;
    in_if.period_ms = '0;
    out_if.ready    = 1'b0;
    now_ms_q = '0;
    for (int i = 0; i < NCH; i++) begin
      due_q[i] = mot_pkg::STOPPED;
      per_q[i] = '0;
      rep_q[i] = 1'b0;
    end

    // idle channel, saturating start, every channel firing, disable
    queue_cmd(mot_pkg::OP_QUERY, 3'd0, '0);
    queue_cmd(mot_pkg::OP_SET_PERIOD, 3'd7, mot_pkg::DUE_MAX);
    queue_cmd(mot_pkg::OP_START_ONCE, 3'd7, '0);
    queue_cmd(mot_pkg::OP_START_PERIODIC, 3'd0, '0);
    queue_cmd(mot_pkg::OP_START_ONCE, 3'd1, '0);
    queue_cmd(mot_pkg::OP_START_PERIODIC, 3'd2, '0);
    queue_cmd(mot_pkg::OP_START_ONCE, 3'd3, '0);
    queue_cmd(mot_pkg::OP_START_PERIODIC, 3'd4, '0);
    queue_cmd(mot_pkg::OP_START_ONCE, 3'd5, '0);
    queue_cmd(mot_pkg::OP_START_PERIODIC, 3'd6, '0);
    queue_cmd(mot_pkg::OP_TICK, 3'd0, '0);
    queue_cmd(mot_pkg::OP_SET_PERIOD, 3'd7, '0);
    queue_cmd(mot_pkg::OP_START_PERIODIC, 3'd7, '0);
    queue_cmd(mot_pkg::OP_START_PERIODIC, 3'd1, '0);
    queue_cmd(mot_pkg::OP_START_ONCE, 3'd3, '0);
    queue_cmd(mot_pkg::OP_START_ONCE, 3'd5, '0);
    queue_cmd(mot_pkg::OP_TICK, 3'd7, 32'hFFFF_FFFE);
    queue_cmd(mot_pkg::OP_DISABLE, 3'd0, '0);
    queue_cmd(mot_pkg::OP_SET_PERIOD, 3'd2, 32'd3);
    queue_cmd(mot_pkg::OP_TICK, 3'd2, '0);
    queue_cmd(mot_pkg::OP_TICK, 3'd5, 32'h5555_5555);
    queue_cmd(mot_pkg::OP_QUERY, 3'd2, 32'hAAAA_AAAA);
    queue_cmd(mot_pkg::OP_SET_PERIOD, 3'd4, 32'h8000_0001);
    queue_cmd(mot_pkg::OP_START_PERIODIC, 3'd4, '0);
    queue_cmd(mot_pkg::OP_TICK, 3'd0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin send_idle_pct = 77; out_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  out_stall_pct = 77; end
        default: begin send_idle_pct = 25; out_stall_pct = 25; end
      endcase
      repeat (RANDOM_PER_PHASE) queue_random_cmd();
      // hold off new items until every result is back
      while (pending_cmds.size() > 0 || in_if.valid || expected_results.size() > 0)
        @(posedge clk);
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("multichannel_oneshot_periodic_timer: match");
    else
      $display("multichannel_oneshot_periodic_timer: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mot_pkg.sv
hdl/mot_if.sv
hdl/mot_ctrl.sv
hdl/mot_dp.sv
hdl/multichannel_oneshot_periodic_timer.sv
hdl/mot_checker.sv
sim/multichannel_oneshot_periodic_timer_tb.sv
